// ===== src/ppdd_pkg.sv =====
// Shared constants for the pulse pair digit decoder.
package ppdd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned LEVEL_W         = 16;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned POS_W           = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd1;

  // Decode modes; bit 1 high selects key mode.
  localparam logic [MODE_W-1:0] MODE_DIGIT_LSB = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIGIT_MSB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY       = 2'd2;

  // Sample offsets inside one code bit.
  localparam logic [3:0] Q_FIRST_START  = 4'd0;
  localparam logic [3:0] Q_FIRST_PAIR   = 4'd1;
  localparam logic [3:0] Q_FIRST_END    = 4'd7;
  localparam logic [3:0] Q_SECOND_START = 4'd8;
  localparam logic [3:0] Q_SECOND_PAIR  = 4'd9;
  localparam logic [3:0] Q_BIT_END      = 4'd15;

  // Key patterns, first bit in the most significant place.
  localparam logic [2:0] KEY_PAT_1 = 3'b110;
  localparam logic [2:0] KEY_PAT_2 = 3'b000;
  localparam logic [2:0] KEY_PAT_3 = 3'b101;

  localparam logic [3:0] KEY_VAL_1 = 4'd1;
  localparam logic [3:0] KEY_VAL_2 = 4'd2;
  localparam logic [3:0] KEY_VAL_3 = 4'd3;

  localparam logic [6:0] STAR_CHAR = 7'd42;
  localparam logic [6:0] ZERO_CHAR = 7'd48;

  function automatic logic [3:0] reverse4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

endpackage

// ===== src/pulse_pair_digit_decoder_core.sv =====
// Pulse pair digit decoder: sample stream in, one decoded digit or key per group out.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_ready_o | sample_i, group_start_i
//  out     | output    | out_valid_o/out_ready_i | code_value_o, symbol_o, code_error_o
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One sample item per cycle while in_ready_o is high. Each item of an open group updates
// the group state in the cycle it is accepted; the last sample of a group loads the result
// register at its accepting edge, so the code shows on the outputs in the cycle after.
// The result register parts the two sides: a new sample is taken while the result
// waits, unless the result is stalled and this sample would produce another one,
// in which case in_ready_o stays low until the output drains.
// Reset clears the configuration registers, the group state and the output valid.
module pulse_pair_digit_decoder_core #(
  parameter int unsigned SAMPLE_BITS = ppdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ppdd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           group_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [3:0]                     code_value_o,
  output logic [6:0]                     symbol_o,
  output logic                           code_error_o,
  input  logic                           cfg_we_i,
  input  logic [ppdd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppdd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned PAIR_W = SAMPLE_BITS + 1;
  localparam int unsigned HALF_W = SAMPLE_BITS + 3;
  localparam int unsigned CMP_W  = ppdd_pkg::LEVEL_W + 3;

  // Configuration registers.
  logic [ppdd_pkg::LEVEL_W-1:0] pulse_level_q;
  logic [ppdd_pkg::MODE_W-1:0]  decode_mode_q;

  // Group state.
  logic [ppdd_pkg::POS_W-1:0] pos_q, pos_d;
  logic                       active_q, active_d;
  logic [PAIR_W-1:0]          pair_q, pair_d;
  logic [HALF_W-1:0]          half_q, half_d;
  logic                       fhh_q, fhh_d;
  logic                       fhl_q, fhl_d;
  logic                       shh_q, shh_d;
  logic [3:0]                 bits_q, bits_d;
  logic                       err_q, err_d;

  // Result register.
  logic       out_valid_q;
  logic [3:0] value_q, value_d;
  logic [6:0] sym_q, sym_d;
  logic       cerr_q, cerr_d;
  logic       emit;

  logic in_fire;

  // Take a sample whenever the output is free or drains this cycle; a stalled
  // result only blocks when this sample would close a group.
  assign in_ready_o = !out_valid_q || out_ready_i || !emit;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic [SAMPLE_BITS-1:0] s;
    logic [3:0]             q;
    logic [CMP_W-1:0]       pair_mean;
    logic [CMP_W-1:0]       half_mean;
    logic [CMP_W-1:0]       level;
    logic                   key_mode;
    logic                   bit_v;
    logic                   shl;
    logic [2:0]             bits_done;
    logic [2:0]             need;
    logic [3:0]             val;
    logic                   e;

    s        = sample_i[SAMPLE_BITS-1:0];
    level    = CMP_W'(pulse_level_q);
    key_mode = decode_mode_q[1];

    // Restart a group on the start marker, drop any group in progress.
    active_d = active_q || group_start_i;
    pos_d    = group_start_i ? '0 : pos_q;
    fhh_d    = group_start_i ? 1'b0 : fhh_q;
    fhl_d    = group_start_i ? 1'b0 : fhl_q;
    shh_d    = group_start_i ? 1'b0 : shh_q;
    bits_d   = group_start_i ? '0 : bits_q;
    err_d    = group_start_i ? 1'b0 : err_q;
    pair_d   = pair_q;
    half_d   = half_q;
    emit     = 1'b0;
    value_d  = value_q;
    sym_d    = sym_q;
    cerr_d   = cerr_q;

    q = pos_d[3:0];

    if (q == ppdd_pkg::Q_FIRST_START || q == ppdd_pkg::Q_SECOND_START) begin
      pair_d = PAIR_W'(s);
      half_d = HALF_W'(s);
    end else begin
      half_d = half_q + HALF_W'(s);
      if (q == ppdd_pkg::Q_FIRST_PAIR || q == ppdd_pkg::Q_SECOND_PAIR) begin
        pair_d = pair_q + PAIR_W'(s);
      end
    end

    pair_mean = CMP_W'(pair_d >> 1);
    half_mean = CMP_W'(half_d >> 3);
    shl       = half_mean < level;

    if (q == ppdd_pkg::Q_FIRST_PAIR) begin
      fhh_d = pair_mean > level;
    end
    if (q == ppdd_pkg::Q_SECOND_PAIR) begin
      shh_d = pair_mean > level;
    end
    if (q == ppdd_pkg::Q_FIRST_END) begin
      fhl_d = shl;
    end

    bits_done = 3'(pos_d[5:4]) + 3'd1;
    need      = key_mode ? 3'd3 : 3'd4;
    bit_v     = 1'b0;
    val       = '0;
    e         = 1'b0;

    if (q == ppdd_pkg::Q_BIT_END) begin
      // Judge the bit: pulse then gap is a one, gap then pulse is a zero.
      if (fhh_d && shl) begin
        bit_v = 1'b1;
      end else if (shh_d && fhl_d) begin
        bit_v = 1'b0;
      end else begin
        err_d = 1'b1;
      end
      bits_d = {bits_d[2:0], bit_v};

      if (bits_done >= need) begin
        emit = active_d;
        e    = err_d;
        if (key_mode) begin
          unique case (bits_d[2:0])
            ppdd_pkg::KEY_PAT_1: val = ppdd_pkg::KEY_VAL_1;
            ppdd_pkg::KEY_PAT_2: val = ppdd_pkg::KEY_VAL_2;
            ppdd_pkg::KEY_PAT_3: val = ppdd_pkg::KEY_VAL_3;
            default:             e   = 1'b1;
          endcase
          value_d = e ? '0 : val;
          sym_d   = '0;
        end else begin
          val     = (decode_mode_q == ppdd_pkg::MODE_DIGIT_LSB) ?
                    ppdd_pkg::reverse4(bits_d) : bits_d;
          value_d = e ? '0 : val;
          sym_d   = e ? ppdd_pkg::STAR_CHAR : (ppdd_pkg::ZERO_CHAR + 7'(val));
        end
        cerr_d   = e;
        active_d = 1'b0;
        pos_d    = '0;
      end else begin
        pos_d = pos_d + ppdd_pkg::POS_W'(1);
      end
    end else begin
      pos_d = pos_d + ppdd_pkg::POS_W'(1);
    end

    // Idle samples leave the state alone and give nothing.
    if (!active_d && !emit) begin
      pos_d = pos_q;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_level_q <= '0;
      decode_mode_q <= ppdd_pkg::MODE_DIGIT_LSB;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppdd_pkg::CFG_PULSE_LEVEL: pulse_level_q <= cfg_wdata_i[ppdd_pkg::LEVEL_W-1:0];
        ppdd_pkg::CFG_DECODE_MODE: decode_mode_q <= cfg_wdata_i[ppdd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Group state advances only on an accepted sample of an open group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      pair_q   <= '0;
      half_q   <= '0;
      fhh_q    <= 1'b0;
      fhl_q    <= 1'b0;
      shh_q    <= 1'b0;
      bits_q   <= '0;
      err_q    <= 1'b0;
    end else if (in_fire && (active_q || group_start_i)) begin
      pos_q    <= pos_d;
      active_q <= active_d;
      pair_q   <= pair_d;
      half_q   <= half_d;
      fhh_q    <= fhh_d;
      fhl_q    <= fhl_d;
      shh_q    <= shh_d;
      bits_q   <= bits_d;
      err_q    <= err_d;
    end
  end

  // Output register: load on a closing sample, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      value_q <= value_d;
      sym_q   <= sym_d;
      cerr_q  <= cerr_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_value_o = value_q;
  assign symbol_o     = sym_q;
  assign code_error_o = cerr_q;

endmodule

// ===== src/ppdd_checker.sv =====
// Port-level checks for the pulse pair digit decoder, bound to the top level.
module ppdd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [3:0]                      code_value_o,
  input logic [6:0]                      symbol_o,
  input logic                            code_error_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_value_o) &&
    $stable(symbol_o) && $stable(code_error_o))
    else $error("stalled result changed");

  // With the result register empty the input side never stalls.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // An error result carries value zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_error_o |-> code_value_o == 4'd0)
    else $error("error result with nonzero value");

  // A good digit shows its ASCII character.
  a_digit_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !code_error_o && symbol_o != 7'd0 |->
    symbol_o == ppdd_pkg::ZERO_CHAR + 7'(code_value_o))
    else $error("digit symbol mismatch");

  // A good key is one of keys 1 to 3.
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !code_error_o && symbol_o == 7'd0 |->
    code_value_o == 4'd1 || code_value_o == 4'd2 || code_value_o == 4'd3)
    else $error("key value out of range");

endmodule

bind pulse_pair_digit_decoder_core ppdd_checker u_ppdd_checker (.*);

// ===== dv/ppdd_code_checker.sv =====
// Result checker for the pulse pair digit decoder: tracks the group state and compares codes.
module ppdd_code_checker #(
  parameter int unsigned SAMPLE_BITS = ppdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [ppdd_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                            group_start_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [3:0]                      code_value_i,
  input  logic [6:0]                      symbol_i,
  input  logic                            code_error_i,
  input  logic                            cfg_we_i,
  input  logic [ppdd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppdd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] value;
    logic [6:0] symbol;
    logic       error;
  } code_t;

  localparam logic [ppdd_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    ppdd_pkg::SAMPLE_W'((64'd1 << SAMPLE_BITS) - 1);

  logic [ppdd_pkg::LEVEL_W-1:0] level;
  logic [ppdd_pkg::MODE_W-1:0]  mode;
  logic [ppdd_pkg::POS_W-1:0]   pos;
  logic                         active;
  logic [16:0]                  pair_sum;
  logic [18:0]                  half_sum;
  logic                         hi_first;
  logic                         lo_first;
  logic                         hi_second;
  logic [3:0]                   bits;
  logic                         bad_bit;
  code_t                        expected_codes[$];

  // Advance the group state by one sample; queue a code at the end of a group.
  task automatic decode_sample(input logic [ppdd_pkg::SAMPLE_W-1:0] raw, input logic start);
    logic [ppdd_pkg::SAMPLE_W-1:0] s;
    logic [3:0]                    q;
    logic                          lo_second;
    logic                          bit_val;
    logic                          key_mode;
    logic                          err;
    logic [2:0]                    bits_done;
    logic [2:0]                    bits_need;
    code_t                         res;
    s = raw & SAMPLE_MASK;
    if (start) begin
      active    = 1'b1;
      pos       = '0;
      bits      = '0;
      bad_bit   = 1'b0;
      hi_first  = 1'b0;
      lo_first  = 1'b0;
      hi_second = 1'b0;
    end
    if (!active) return;
    q = pos[3:0];
    if (q == ppdd_pkg::Q_FIRST_START || q == ppdd_pkg::Q_SECOND_START) begin
      pair_sum = 17'(s);
      half_sum = 19'(s);
    end else begin
      half_sum = half_sum + 19'(s);
      if (q == ppdd_pkg::Q_FIRST_PAIR || q == ppdd_pkg::Q_SECOND_PAIR) begin
        pair_sum = pair_sum + 17'(s);
        if (q == ppdd_pkg::Q_FIRST_PAIR) hi_first = pair_sum[16:1] > level;
        else hi_second = pair_sum[16:1] > level;
      end
    end
    if (q == ppdd_pkg::Q_FIRST_END) lo_first = half_sum[18:3] < level;
    if (q == ppdd_pkg::Q_BIT_END) begin
      lo_second = half_sum[18:3] < level;
      bit_val   = 1'b0;
      if (hi_first && lo_second) bit_val = 1'b1;
      else if (!(hi_second && lo_first)) bad_bit = 1'b1;
      bits      = {bits[2:0], bit_val};
      bits_done = {1'b0, pos[5:4]} + 3'd1;
      // mode bit 1 selects key mode, so the undefined mode acts as key mode
      key_mode  = mode[1];
      bits_need = key_mode ? 3'd3 : 3'd4;
      if (bits_done >= bits_need) begin
        err = bad_bit;
        res = '0;
        if (key_mode) begin
          if (!err) begin
            case (bits[2:0])
              ppdd_pkg::KEY_PAT_1: res.value = ppdd_pkg::KEY_VAL_1;
              ppdd_pkg::KEY_PAT_2: res.value = ppdd_pkg::KEY_VAL_2;
              ppdd_pkg::KEY_PAT_3: res.value = ppdd_pkg::KEY_VAL_3;
              default:             err = 1'b1;
            endcase
          end
        end else if (err) begin
          res.symbol = ppdd_pkg::STAR_CHAR;
        end else begin
          if (mode == ppdd_pkg::MODE_DIGIT_LSB) res.value = {<<{bits}};
          else res.value = bits;
          res.symbol = ppdd_pkg::ZERO_CHAR + 7'(res.value);
        end
        res.error = err;
        expected_codes.push_back(res);
        active = 1'b0;
        pos    = '0;
        return;
      end
    end
    pos = pos + 1'b1;
  endtask

  task automatic check_code(input code_t got);
    code_t want;
    if (expected_codes.size() == 0) begin
      if (fail_cnt_o < 10)
        $display("%0t: code with none pending: value %0d symbol %0d error %0b",
                 $realtime, got.value, got.symbol, got.error);
      fail_cnt_o++;
    end else begin
      want = expected_codes.pop_front();
      if (got != want) begin
        if (fail_cnt_o < 10)
          $display("%0t: code mismatch: expected value %0d symbol %0d error %0b, got %0d %0d %0b",
                   $realtime, want.value, want.symbol, want.error,
                   got.value, got.symbol, got.error);
        fail_cnt_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level      = '0;
      mode       = '0;
      pos        = '0;
      active     = 1'b0;
      pair_sum   = '0;
      half_sum   = '0;
      hi_first   = 1'b0;
      lo_first   = 1'b0;
      hi_second  = 1'b0;
      bits       = '0;
      bad_bit    = 1'b0;
      fail_cnt_o = 0;
      pending_o  = 0;
      expected_codes.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ppdd_pkg::CFG_PULSE_LEVEL) begin
          level = cfg_wdata_i[ppdd_pkg::LEVEL_W-1:0];
        end else if (cfg_idx_i == ppdd_pkg::CFG_DECODE_MODE) begin
          mode = cfg_wdata_i[ppdd_pkg::MODE_W-1:0];
        end
      end
      // the code taken now is older than any code this edge's sample could add
      if (out_valid_i && out_ready_i) check_code({code_value_i, symbol_i, code_error_i});
      if (in_valid_i && in_ready_i) decode_sample(sample_i, group_start_i);
      pending_o = expected_codes.size();
    end
  end

endmodule

// ===== dv/tb_pulse_pair_digit_decoder_core.sv =====
// Top of the pulse pair digit decoder testbench: sample and configuration stimulus, verdict.
module tb_pulse_pair_digit_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1650;  // samples that reach a group
  localparam int unsigned CALM_TAIL   = 250;   // last samples sent with no idling
  localparam int unsigned SETTLE_CYC  = 4;     // result register plus margin
  localparam int unsigned BIT_LEN     = 16;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [ppdd_pkg::SAMPLE_W-1:0]   sample      = '0;
  logic                            group_start = 1'b0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic [3:0]                      code_value;
  logic [6:0]                      symbol;
  logic                            code_error;
  logic                            cfg_we      = 1'b0;
  logic [ppdd_pkg::CFG_IDX_W-1:0]  cfg_idx     = ppdd_pkg::CFG_PULSE_LEVEL;
  logic [ppdd_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;

  int                              fail_cnt;
  int                              pending_cnt;
  bit                              idle_on     = 1'b0;
  logic [ppdd_pkg::LEVEL_W-1:0]    cur_level   = '0;
  logic [ppdd_pkg::MODE_W-1:0]     cur_mode    = ppdd_pkg::MODE_DIGIT_LSB;
  int                              items_sent  = 0;

  always #6 clk_i = ~clk_i;

  pulse_pair_digit_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample),
    .group_start_i (group_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_value_o  (code_value),
    .symbol_o      (symbol),
    .code_error_o  (code_error),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  ppdd_code_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_i      (sample),
    .group_start_i (group_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .code_value_i  (code_value),
    .symbol_i      (symbol),
    .code_error_i  (code_error),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending_cnt)
  );

  // Pick a sample on the wanted side of the current level. When that side is
  // empty (level at an extreme) any value will do; the bit is then malformed.
  // Now and then hit the level itself or its direct neighbors to exercise the
  // strict compares and the truncating means.
  function automatic logic [ppdd_pkg::SAMPLE_W-1:0] level_side(input bit hi, input bit ext);
    logic [ppdd_pkg::SAMPLE_W-1:0] v;
    int                            r;
    r = $urandom_range(0, 15);
    if ((hi && cur_level == '1) || (!hi && cur_level == '0)) v = 16'($urandom);
    else if (ext) v = hi ? '1 : '0;
    else if (r == 0) v = hi ? cur_level + 1'b1 : cur_level - 1'b1;
    else if (r == 1) v = cur_level;
    else if (hi) v = 16'($urandom_range(int'(cur_level) + 1, 65535));
    else v = 16'($urandom_range(0, int'(cur_level) - 1));
    return v;
  endfunction

  // Offer one sample item and hold it until taken. Ready is checked on the
  // falling edge, where nothing moves until the next rising edge.
  task automatic send_sample(input logic [ppdd_pkg::SAMPLE_W-1:0] s, input logic st);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    sample      <= s;
    group_start <= st;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  // Send a code group: bits go out from seq[nbits-1] down, 16 samples each.
  // A one puts a pulse pair at the head of the first half and keeps the whole
  // second half low; a zero mirrors that. Bits flagged in bad get plain noise.
  // Stop after cut samples, which lets a later start drop the group.
  task automatic send_group(input logic [3:0] seq, input int nbits, input logic [3:0] bad,
                            input bit ext, input int cut);
    int                            n;
    logic                          b;
    logic [ppdd_pkg::SAMPLE_W-1:0] s;
    n = 0;
    for (int k = nbits - 1; k >= 0; k--) begin
      b = seq[k];
      for (int q = 0; q < BIT_LEN; q++) begin
        if (n < cut) begin
          if (bad[k]) s = 16'($urandom);
          else if (q < int'(ppdd_pkg::Q_SECOND_START))
            s = !b ? level_side(1'b0, ext)
                   : (q <= int'(ppdd_pkg::Q_FIRST_PAIR)) ? level_side(1'b1, ext)
                                                         : 16'($urandom);
          else
            s = b ? level_side(1'b0, ext)
                  : (q <= int'(ppdd_pkg::Q_SECOND_PAIR)) ? level_side(1'b1, ext)
                                                         : 16'($urandom);
          send_sample(s, n == 0);
          n++;
        end
      end
    end
    items_sent += n;
  endtask

  // Drop valid, hold off until every code has come out, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write one register, only with the decoder drained.
  task automatic set_reg(input logic [ppdd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ppdd_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == ppdd_pkg::CFG_PULSE_LEVEL) cur_level = data[ppdd_pkg::LEVEL_W-1:0];
    else if (idx == ppdd_pkg::CFG_DECODE_MODE) cur_mode = data[ppdd_pkg::MODE_W-1:0];
  endtask

  // Receiver: take codes, with random stall bursts while idling is on.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    int                          n_groups;
    int                          kind;
    int                          nbits;
    int                          cut;
    logic [3:0]                  seq;
    logic [3:0]                  bad;
    logic [15:0]                 lvl;
    logic [ppdd_pkg::MODE_W-1:0] m;
    bit                          ext;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling.
    // Samples without a start while no group is open are dropped.
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    // Level zero: nothing can sit below it, so every bit is malformed.
    set_reg(ppdd_pkg::CFG_PULSE_LEVEL, 16'h0000);
    set_reg(ppdd_pkg::CFG_DECODE_MODE, 16'(ppdd_pkg::MODE_DIGIT_LSB));
    send_group(4'b1010, 4, 4'b0000, 1'b0, 64);
    // Mid level, digit LSB first, samples pinned at the field extremes.
    set_reg(ppdd_pkg::CFG_PULSE_LEVEL, 16'h8000);
    send_group(4'b0000, 4, 4'b0000, 1'b1, 64);
    send_group(4'b1111, 4, 4'b0000, 1'b1, 64);
    // Digit MSB first, then one malformed bit and a group dropped by a restart.
    set_reg(ppdd_pkg::CFG_DECODE_MODE, 16'(ppdd_pkg::MODE_DIGIT_MSB));
    send_group(4'b1001, 4, 4'b0000, 1'b0, 64);
    send_group(4'b0110, 4, 4'b0100, 1'b0, 64);
    send_group(4'b0011, 4, 4'b0000, 1'b0, 37);
    send_group(4'b1100, 4, 4'b0000, 1'b0, 64);
    // Key mode: each known pattern and an unknown one.
    set_reg(ppdd_pkg::CFG_DECODE_MODE, 16'(ppdd_pkg::MODE_KEY));
    send_group({1'b0, ppdd_pkg::KEY_PAT_1}, 3, 4'b0000, 1'b0, 48);
    send_group({1'b0, ppdd_pkg::KEY_PAT_2}, 3, 4'b0000, 1'b0, 48);
    send_group({1'b0, ppdd_pkg::KEY_PAT_3}, 3, 4'b0000, 1'b0, 48);
    send_group(4'b0111, 3, 4'b0000, 1'b0, 48);
    // Undefined mode decodes as key mode.
    set_reg(ppdd_pkg::CFG_DECODE_MODE, 16'(ppdd_pkg::MODE_KEY | ppdd_pkg::MODE_DIGIT_MSB));
    send_group({1'b0, ppdd_pkg::KEY_PAT_3}, 3, 4'b0000, 1'b0, 48);
    // Top level: no pair mean can exceed it.
    set_reg(ppdd_pkg::CFG_PULSE_LEVEL, 16'hFFFF);
    send_group({1'b0, ppdd_pkg::KEY_PAT_1}, 3, 4'b0000, 1'b0, 48);

    // Random part: one setting per phase, mostly well-formed groups.
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      idle_on = (items_sent + CALM_TAIL < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       lvl = 16'h0000;
        1:       lvl = 16'hFFFF;
        2:       lvl = 16'($urandom_range(1, 255));
        3:       lvl = 16'($urandom_range(65280, 65534));
        default: lvl = 16'($urandom);
      endcase
      set_reg(ppdd_pkg::CFG_PULSE_LEVEL, lvl);
      m = ppdd_pkg::MODE_W'($urandom_range(0, 3));
      // junk in the unused upper bits of the mode write
      set_reg(ppdd_pkg::CFG_DECODE_MODE, {14'($urandom), m});
      n_groups = $urandom_range(2, 6);
      for (int g = 0; g < n_groups; g++) begin
        kind  = $urandom_range(0, 15);
        nbits = cur_mode[1] ? 3 : 4;
        if (cur_mode[1]) begin
          case ($urandom_range(0, 3))
            0:       seq = {1'b0, ppdd_pkg::KEY_PAT_1};
            1:       seq = {1'b0, ppdd_pkg::KEY_PAT_2};
            2:       seq = {1'b0, ppdd_pkg::KEY_PAT_3};
            default: seq = 4'($urandom);
          endcase
        end else begin
          seq = 4'($urandom);
        end
        bad = (kind == 0) ? 4'($urandom) : 4'b0000;
        ext = (kind == 1);
        // stray samples: dropped when no group is open, else part of the group
        if (kind == 3)
          repeat ($urandom_range(1, 3)) send_sample(16'($urandom), 1'b0);
        // group one bit too long or too short for the mode
        if (kind == 4) nbits = 7 - nbits;
        cut = (kind == 2) ? $urandom_range(1, nbits * BIT_LEN - 1) : nbits * BIT_LEN;
        send_group(seq, nbits, bad, ext, cut);
      end
    end

    idle_on = 1'b0;
    wait_idle();
    @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
